// ===== src/tms_pkg.sv =====
// tms_pkg: shared types and codes for the turing machine stepper
// used by tms_cell and turing_machine_stepper; depends on nothing
`default_nettype none

package tms_pkg;

	localparam logic [1:0] ACT_LOAD_RULE  = 2'd0;
	localparam logic [1:0] ACT_WRITE_CELL = 2'd1;
	localparam logic [1:0] ACT_START      = 2'd2;
	localparam logic [1:0] ACT_STEP       = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [5:0] rule_index;
		logic [7:0] rule_state;
		logic [7:0] rule_read;
		logic [7:0] rule_write;
		logic       rule_right;
		logic [7:0] rule_next;
		logic [7:0] cell_addr;
		logic [7:0] cell_symbol;
	} tms_item_t;

	typedef struct packed {
		logic       halted;
		logic       head_error;
		logic [7:0] state_now;
		logic [7:0] head_now;
		logic [7:0] symbol_written;
	} tms_result_t;

	// one stored transition
	typedef struct packed {
		logic [7:0] st;
		logic [7:0] rd;
		logic [7:0] wr;
		logic       right;
		logic [7:0] nx;
	} tms_rule_t;

	// the part of a rule that a step applies
	typedef struct packed {
		logic [7:0] wr;
		logic       right;
		logic [7:0] nx;
	} tms_act_t;

	// broadcast from the sequencer to every rule cell
	typedef struct packed {
		logic       load;
		logic       cmp;
		logic [5:0] load_idx;
		logic [6:0] rule_count;
		logic [7:0] state;
		logic [7:0] sym;
	} tms_cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PICK,
		ST_APPLY,
		ST_FETCH,
		ST_EMIT
	} tms_state_t;

endpackage

`default_nettype wire

// ===== src/tms_ram.sv =====
// tms_ram: generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module tms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/tms_cell.sv =====
// tms_cell: one rule slot, holds a transition and compares it against the
// current state and tape symbol; depends on tms_pkg
`default_nettype none

module tms_cell import tms_pkg::*; #(
	parameter int IDX = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  tms_cell_ctl_t      ctl,
	input  tms_rule_t          rule_in,
	input  wire logic          grant,
	output logic               match_s1,
	output tms_act_t           act_out
);

	tms_rule_t rule_q;
	logic      in_use;

	always_ff @(posedge clk) begin
		if (ctl.load && (32'(ctl.load_idx) == IDX)) begin
			rule_q <= rule_in;
		end
	end

	// slots at or above the rule count take no part in the search
	assign in_use = 32'(ctl.rule_count) > IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_s1 <= 1'b0;
		end else if (ctl.cmp) begin
			match_s1 <= in_use && (rule_q.st == ctl.state) && (rule_q.rd == ctl.sym);
		end
	end

	assign act_out.wr    = grant ? rule_q.wr : 8'd0;
	assign act_out.right = grant & rule_q.right;
	assign act_out.nx    = grant ? rule_q.nx : 8'd0;

endmodule

`default_nettype wire

// ===== src/turing_machine_stepper.sv =====
// turing_machine_stepper: top level, sequencer, rule cell row and tape ram
// depends on tms_pkg, tms_cell, tms_ram
//
// channel   direction  handshake             payload
// item      in         start & !busy         item   (tms_item_t)
// result    out        done, one cycle       result (tms_result_t)
// config    in         cfg_we, no wait       cfg_data (rule_count)
//
// a step word passes through tape read and compare in the rule cells, first-match
// pick, apply and result from acceptance to done; other words pass through
// execute, tape read at the head and result. the tape ram's single read port
// sets the fetch cycles. a new word may be accepted in the cycle done is high.
// reset clears the machine state to 0, head to cell 1 and rule_count to 0;
// rule slots and tape are undefined until written. results cannot be stalled.
`default_nettype none

module turing_machine_stepper import tms_pkg::*; #(
	parameter int RULE_SLOTS = 64,
	parameter int TAPE_CELLS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  tms_item_t        item,
	output logic             done,
	output tms_result_t      result,
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_data
);

	localparam int HW = $clog2(TAPE_CELLS);
	localparam int AW = (HW > 8) ? HW : 8;

	tms_state_t state_q, state_d;

	tms_item_t     item_q;
	logic [6:0]    rule_count_q;
	logic [7:0]    mstate_q;
	logic [HW-1:0] head_q;
	logic [7:0]    sym_q;

	logic [RULE_SLOTS-1:0] match_v;
	logic [RULE_SLOTS-1:0] grant_v;
	tms_act_t              acts [RULE_SLOTS];
	tms_act_t              sel;
	tms_act_t              sel_s2;
	logic                  hit_s2;

	logic          halted_q;
	logic          herr_q;
	logic [7:0]    symw_q;
	logic          use_rd_q;

	tms_cell_ctl_t cell_ctl;
	tms_rule_t     rule_in;

	logic          accept;
	logic          is_step;
	logic [AW-1:0] cell_ext;
	logic [AW-1:0] head_ext;
	logic          cell_ok;

	logic          ram_we;
	logic [HW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	logic          at_last;
	logic          at_first;
	logic          move_err;

	assign accept  = start && !busy;
	assign is_step = item_q.action == ACT_STEP;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = is_step ? ST_PICK : ST_FETCH;
			end
			ST_PICK: begin
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				state_d = ST_EMIT;
			end
			ST_FETCH: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				busy    = 1'b0;
				done    = 1'b1;
				state_d = start ? ST_EXEC : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count_q <= 7'd0;
		end else if (cfg_we) begin
			rule_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	// rule cell row
	assign cell_ctl.load       = (state_q == ST_EXEC) && (item_q.action == ACT_LOAD_RULE);
	assign cell_ctl.cmp        = (state_q == ST_EXEC) && is_step;
	assign cell_ctl.load_idx   = item_q.rule_index;
	assign cell_ctl.rule_count = rule_count_q;
	assign cell_ctl.state      = mstate_q;
	assign cell_ctl.sym        = ram_rdata;

	assign rule_in.st    = item_q.rule_state;
	assign rule_in.rd    = item_q.rule_read;
	assign rule_in.wr    = item_q.rule_write;
	assign rule_in.right = item_q.rule_right;
	assign rule_in.nx    = item_q.rule_next;

	// lowest matching slot wins
	assign grant_v = match_v & ((~match_v) + RULE_SLOTS'(1));

	for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_cell
		tms_cell #(
			.IDX(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.rule_in (rule_in),
			.grant   (grant_v[i]),
			.match_s1(match_v[i]),
			.act_out (acts[i])
		);
	end

	always_comb begin
		sel = '0;
		for (int i = 0; i < RULE_SLOTS; i++) begin
			sel = sel | acts[i];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PICK) begin
			sel_s2 <= sel;
			hit_s2 <= |match_v;
		end
		if (state_q == ST_EXEC) begin
			sym_q <= ram_rdata;
		end
	end

	// tape
	assign cell_ext = AW'(item_q.cell_addr);
	assign cell_ok  = (AW + 1)'(cell_ext) < (AW + 1)'(TAPE_CELLS);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = head_q;
		ram_wdata = sel_s2.wr;
		if ((state_q == ST_EXEC) && (item_q.action == ACT_WRITE_CELL) && cell_ok) begin
			ram_we    = 1'b1;
			ram_waddr = cell_ext[HW-1:0];
			ram_wdata = item_q.cell_symbol;
		end else if ((state_q == ST_APPLY) && hit_s2) begin
			ram_we = 1'b1;
		end
	end

	tms_ram #(
		.WIDTH(8),
		.DEPTH(TAPE_CELLS)
	) u_tape (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	// machine state and head
	assign at_last  = head_q == HW'(TAPE_CELLS - 1);
	assign at_first = head_q == '0;
	assign move_err = sel_s2.right ? at_last : at_first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mstate_q <= 8'd0;
			head_q   <= HW'(1);
		end else if ((state_q == ST_EXEC) && (item_q.action == ACT_START)) begin
			mstate_q <= 8'd0;
			head_q   <= HW'(1);
		end else if ((state_q == ST_APPLY) && hit_s2) begin
			mstate_q <= sel_s2.nx;
			if (!move_err) begin
				head_q <= sel_s2.right ? head_q + HW'(1) : head_q - HW'(1);
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (state_q == ST_APPLY) begin
			halted_q <= !hit_s2;
			herr_q   <= hit_s2 && move_err;
			symw_q   <= hit_s2 ? sel_s2.wr : sym_q;
			use_rd_q <= 1'b0;
		end else if (state_q == ST_FETCH) begin
			halted_q <= 1'b0;
			herr_q   <= 1'b0;
			use_rd_q <= 1'b1;
		end
	end

	assign head_ext              = AW'(head_q);
	assign result.halted         = halted_q;
	assign result.head_error     = herr_q;
	assign result.state_now      = mstate_q;
	assign result.head_now       = head_ext[7:0];
	assign result.symbol_written = use_rd_q ? ram_rdata : symw_q;

`ifndef NO_ASSERTIONS
	a_step_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (item.action == ACT_STEP) |-> ##4 done)
		else $error("step word did not finish in four cycles");

	a_other_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (item.action != ACT_STEP) |-> ##3 done)
		else $error("non-step word did not finish in three cycles");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_one_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PICK) |-> $onehot0(grant_v))
		else $error("more than one rule granted");

	a_halt_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.halted |-> !result.head_error)
		else $error("halted step flagged a head error");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(head_q) < TAPE_CELLS)
		else $error("head left the tape");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_turing_machine_stepper.sv =====
// tb_turing_machine_stepper: self-checking bench for the turing machine stepper
// a directed table runs first, then machine programs and noise, checked against the
// table or an in-bench model of rules, tape, state and head; depends on tms_pkg, rtl
`timescale 1ns / 1ps

module tb_turing_machine_stepper;
	import tms_pkg::*;

	localparam int RULE_SLOTS = 64;
	localparam int TAPE_CELLS = 256;
	localparam int WORD_TARGET = 1300;
	// bound on the whole run, set far above the worst case for WORD_TARGET words
	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [6:0]  cfg;
		tms_item_t   w;
		logic        typed;
		tms_result_t want;
	} plan_row_t;

	localparam int PLAN_ROWS = 19;
	// field order of a word: action, rule index/state/read/write/right/next, cell addr/symbol
	localparam plan_row_t OPENING_PLAN [PLAN_ROWS] = '{
		'{ROW_CFG, 7'd0, '0, 1'b0, '0},
		'{ROW_WORD, 7'd0, '{ACT_WRITE_CELL, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h01, 8'hA5},
			1'b1, '{1'b0, 1'b0, 8'h00, 8'h01, 8'hA5}},
		'{ROW_WORD, 7'd0, '{ACT_WRITE_CELL, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
			1'b1, '{1'b0, 1'b0, 8'h00, 8'h01, 8'hA5}},
		'{ROW_WORD, 7'd0, '{ACT_WRITE_CELL, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'hFF, 8'hFF},
			1'b1, '{1'b0, 1'b0, 8'h00, 8'h01, 8'hA5}},
		// no rules in play yet, so steps halt and keep halting
		'{ROW_WORD, 7'd0, '{ACT_STEP, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
			1'b1, '{1'b1, 1'b0, 8'h00, 8'h01, 8'hA5}},
		'{ROW_WORD, 7'd0, '{ACT_STEP, 6'h3F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF},
			1'b1, '{1'b1, 1'b0, 8'h00, 8'h01, 8'hA5}},
		'{ROW_WORD, 7'd0, '{ACT_LOAD_RULE, 6'd0, 8'h00, 8'hA5, 8'h3C, 1'b0, 8'h01, 8'h00, 8'h00},
			1'b1, '{1'b0, 1'b0, 8'h00, 8'h01, 8'hA5}},
		'{ROW_WORD, 7'd0, '{ACT_LOAD_RULE, 6'd1, 8'h01, 8'h00, 8'h00, 1'b0, 8'h02, 8'hFF, 8'hFF},
			1'b1, '{1'b0, 1'b0, 8'h00, 8'h01, 8'hA5}},
		'{ROW_WORD, 7'd0, '{ACT_LOAD_RULE, 6'd63, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'h00, 8'h00},
			1'b1, '{1'b0, 1'b0, 8'h00, 8'h01, 8'hA5}},
		'{ROW_CFG, 7'd2, '0, 1'b0, '0},
		'{ROW_WORD, 7'd0, '{ACT_STEP, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
			1'b0, '0},
		// move left off cell 0: the symbol is still written and the state still changes
		'{ROW_WORD, 7'd0, '{ACT_STEP, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
			1'b1, '{1'b0, 1'b1, 8'h02, 8'h00, 8'h00}},
		'{ROW_WORD, 7'd0, '{ACT_STEP, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
			1'b1, '{1'b1, 1'b0, 8'h02, 8'h00, 8'h00}},
		'{ROW_WORD, 7'd0, '{ACT_START, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
			1'b0, '0},
		'{ROW_WORD, 7'd0, '{ACT_WRITE_CELL, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h01, 8'hA5},
			1'b1, '{1'b0, 1'b0, 8'h00, 8'h01, 8'hA5}},
		// same key as slot 0, the lower slot has to win
		'{ROW_WORD, 7'd0, '{ACT_LOAD_RULE, 6'd1, 8'h00, 8'hA5, 8'h55, 1'b1, 8'h03, 8'h00, 8'h00},
			1'b0, '0},
		'{ROW_WORD, 7'd0, '{ACT_STEP, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
			1'b0, '0},
		'{ROW_WORD, 7'd0, '{ACT_LOAD_RULE, 6'd1, 8'h01, 8'h00, 8'h7E, 1'b1, 8'h80, 8'h00, 8'h00},
			1'b0, '0},
		'{ROW_WORD, 7'd0, '{ACT_STEP, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
			1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	tms_item_t   item = '0;
	logic        done;
	tms_result_t result;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_data = 7'd0;

	// machine image kept by the bench
	tms_rule_t   rule_img [RULE_SLOTS];
	logic [7:0]  tape_img [TAPE_CELLS];
	logic [7:0]  state_img = 8'd0;
	logic [7:0]  head_pos = 8'd1;
	int          rules_live = 0;

	tms_result_t reports_due [$];
	tms_result_t last_outcome;
	int          fails = 0;
	int          words_sent = 0;
	int          gap_pct = 18;
	int          cycle_count = 0;

	// symbols and states a generated program draws from
	logic [7:0]  alphabet [4];
	int          alpha_size;
	int          state_span;

	turing_machine_stepper dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic tms_result_t advance_machine(input tms_item_t w);
		tms_result_t r;
		int hit;
		int i;
		r = '0;
		hit = -1;
		case (w.action)
			ACT_LOAD_RULE: begin
				rule_img[w.rule_index] = '{w.rule_state, w.rule_read, w.rule_write,
					w.rule_right, w.rule_next};
			end
			ACT_WRITE_CELL: begin
				tape_img[w.cell_addr] = w.cell_symbol;
			end
			ACT_START: begin
				state_img = 8'd0;
				head_pos = 8'd1;
			end
			default: begin
				for (i = 0; i < rules_live && hit < 0; i++)
					if (rule_img[i].st == state_img && rule_img[i].rd == tape_img[head_pos])
						hit = i;
				if (hit < 0) begin
					r.halted = 1'b1;
				end else begin
					tape_img[head_pos] = rule_img[hit].wr;
					if (rule_img[hit].right) begin
						if (head_pos != 8'(TAPE_CELLS - 1))
							head_pos++;
						else
							r.head_error = 1'b1;
					end else if (head_pos != 8'd0) begin
						head_pos--;
					end else begin
						r.head_error = 1'b1;
					end
					state_img = rule_img[hit].nx;
				end
			end
		endcase
		r.state_now = state_img;
		r.head_now = head_pos;
		// a matching step reports what it wrote, everything else the cell under the head
		r.symbol_written = (w.action == ACT_STEP && hit >= 0) ? rule_img[hit].wr
			: tape_img[head_pos];
		return r;
	endfunction

	function automatic tms_item_t noise_word();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(tms_item_t)-1:0];
	endfunction

	// unused fields carry junk on purpose
	function automatic tms_item_t mk_ctl(input logic [1:0] act);
		tms_item_t w;
		w = noise_word();
		w.action = act;
		return w;
	endfunction

	function automatic tms_item_t mk_rule(input int slot, input logic [7:0] st, rd, wr,
			input logic right, input logic [7:0] nx);
		tms_item_t w;
		w = mk_ctl(ACT_LOAD_RULE);
		w.rule_index = 6'(slot);
		w.rule_state = st;
		w.rule_read = rd;
		w.rule_write = wr;
		w.rule_right = right;
		w.rule_next = nx;
		return w;
	endfunction

	function automatic tms_item_t mk_cell(input logic [7:0] addr, input logic [7:0] sym);
		tms_item_t w;
		w = mk_ctl(ACT_WRITE_CELL);
		w.cell_addr = addr;
		w.cell_symbol = sym;
		return w;
	endfunction

	function automatic logic [7:0] pick_symbol();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] alpha_symbol();
		return alphabet[$urandom_range(0, alpha_size - 1)];
	endfunction

	// state_span is the halt state: no rule of the program starts from it
	function automatic tms_item_t program_rule(input int slot);
		logic [7:0] nx;
		nx = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, state_span));
		return mk_rule(slot, 8'($urandom_range(0, state_span - 1)), alpha_symbol(),
			alpha_symbol(), 1'($urandom_range(0, 1)), nx);
	endfunction

	task automatic send_word(input tms_item_t w, input logic typed = 1'b0,
			input tms_result_t want = '0);
		tms_result_t got;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy !== 1'b0);
		got = advance_machine(w);
		reports_due.push_back(typed ? want : got);
		last_outcome = got;
		words_sent++;
	endtask

	// drain every outstanding word, then write rule_count while the block is idle
	task automatic set_rule_count(input logic [6:0] v);
		start <= 1'b0;
		do @(posedge clk); while (reports_due.size() != 0);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		rules_live = (v > RULE_SLOTS) ? RULE_SLOTS : v;
	endtask

	task automatic run_program(input int slots, input logic [6:0] live);
		int i;
		int budget;
		int halts;
		set_rule_count(live);
		state_span = $urandom_range(1, 4);
		alpha_size = $urandom_range(1, 4);
		foreach (alphabet[i])
			alphabet[i] = pick_symbol();
		for (i = 0; i < slots; i++)
			send_word(program_rule(i));
		// rewrites leave stale and shadowed keys behind
		for (i = $urandom_range(0, 2); i > 0; i--)
			send_word(program_rule($urandom_range(0, slots - 1)));
		for (i = $urandom_range(0, 6); i > 0; i--)
			send_word(mk_cell(8'(i), alpha_symbol()));
		if ($urandom_range(0, 3) == 0)
			send_word(mk_cell(8'($urandom), pick_symbol()));
		send_word(mk_ctl(ACT_START));
		budget = $urandom_range(4, 40);
		halts = 0;
		while (budget > 0 && halts < 2) begin
			if ($urandom_range(0, 3) == 0)
				send_word(mk_cell(head_pos, alpha_symbol()));
			send_word(mk_ctl(ACT_STEP));
			halts = last_outcome.halted ? halts + 1 : 0;
			budget--;
		end
	endtask

	always @(posedge clk) begin
		tms_result_t want;
		if (arst_n && done === 1'b1) begin
			if (reports_due.size() == 0) begin
				$error("result word with nothing expected");
				fails++;
			end else begin
				want = reports_due.pop_front();
				if (result !== want)
					fails++;
				if (result.halted !== want.halted)
					$error("halted: expected %0d, got %0d", want.halted, result.halted);
				if (result.head_error !== want.head_error)
					$error("head_error: expected %0d, got %0d", want.head_error,
						result.head_error);
				if (result.state_now !== want.state_now)
					$error("state_now: expected %0h, got %0h", want.state_now,
						result.state_now);
				if (result.head_now !== want.head_now)
					$error("head_now: expected %0h, got %0h", want.head_now, result.head_now);
				if (result.symbol_written !== want.symbol_written)
					$error("symbol_written: expected %0h, got %0h", want.symbol_written,
						result.symbol_written);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int r;
		int hits;
		int slots;
		logic [7:0] fill;
		logic [6:0] live;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < PLAN_ROWS; r++) begin
			if (OPENING_PLAN[r].kind == ROW_CFG)
				set_rule_count(OPENING_PLAN[r].cfg);
			else
				send_word(OPENING_PLAN[r].w, OPENING_PLAN[r].typed, OPENING_PLAN[r].want);
		end

		// walk right to the last cell with no gaps; this also writes every cell from 1 up
		gap_pct = 0;
		set_rule_count(7'd1);
		fill = pick_symbol();
		send_word(mk_rule(0, 8'd0, fill, fill, 1'b1, 8'd0));
		send_word(mk_ctl(ACT_START));
		hits = 0;
		while (hits < 3) begin
			send_word(mk_cell(head_pos, fill));
			send_word(mk_ctl(ACT_STEP));
			if (last_outcome.head_error)
				hits++;
		end

		// fill every slot, so any rule_count is safe from here on
		gap_pct = 18;
		run_program(RULE_SLOTS, 7'd127);

		while (words_sent < WORD_TARGET) begin
			gap_pct = ($urandom_range(0, 5) == 0) ? 0 : 18;
			if ($urandom_range(0, 3) == 0) begin
				for (r = $urandom_range(4, 16); r > 0; r--)
					send_word(noise_word());
			end else begin
				slots = ($urandom_range(0, 7) == 0) ? $urandom_range(9, RULE_SLOTS)
					: $urandom_range(1, 8);
				case ($urandom_range(0, 7))
					0: live = 7'd0;
					1: live = 7'd127;
					2: live = 7'(RULE_SLOTS);
					3: live = 7'($urandom_range(0, 127));
					default: live = 7'(slots);
				endcase
				run_program(slots, live);
			end
		end

		start <= 1'b0;
		while (reports_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/tms_pkg.sv
src/tms_ram.sv
src/tms_cell.sv
src/turing_machine_stepper.sv
verif/tb_turing_machine_stepper.sv
